[rtl/dtmfs_pkg.sv]
// types, constants and helper functions shared by the dial sequencer
`timescale 1ns / 1ps

package dtmfs_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_TONE = 3'b010,
        MODE_HISS = 3'b100
    } t_mode;

    typedef struct packed {
        logic  vld;
        t_mode kind;
        logic  last;
    } t_ctl;

    typedef struct packed {
        logic       hit;
        logic [1:0] row;
        logic [1:0] col;
    } t_key;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TONE_SAMPLES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TONE_LEVEL   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HISS_LEVEL   = 2'd2;

    localparam logic [15:0] RST_TONE_SAMPLES = 16'd1000;
    localparam logic [15:0] RST_HISS_LEN     = 16'd333;
    localparam logic [6:0]  RST_TONE_LEVEL   = 7'd70;
    localparam logic [7:0]  RST_HISS_LEVEL   = 8'd3;

    // x / 3 for 16-bit x as (x * 43691) >> 17
    localparam logic [32:0] THIRD_RECIP = 33'd43691;
    localparam int          THIRD_SHIFT = 17;

    localparam logic [15:0] NOISE_SEED = 16'hACE1;
    localparam logic [15:0] NOISE_MASK = 16'hB400;

    localparam logic [7:0] MID_SAMPLE = 8'd128;

    localparam int unsigned ROW_FREQ [4] = '{697, 770, 852, 941};
    localparam int unsigned COL_FREQ [4] = '{1209, 1336, 1477, 1633};

    // quarter-wave polynomial, t in q16, result q15
    function automatic logic [15:0] quarter_sine(input logic [63:0] t);
        logic [63:0] t2;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] f;
        logic [63:0] q;
        t2 = (t * t) >> 16;
        a  = 64'd42111 - ((64'd4737 * t2) >> 16);
        b  = 64'd102919 - ((t2 * a) >> 16);
        f  = (t * b) >> 16;
        q  = (f + 64'd1) >> 1;
        return (q > 64'd32767) ? 16'd32767 : q[15:0];
    endfunction

    function automatic t_key dial_key(input logic [7:0] c);
        t_key k;
        k = '{hit: 1'b1, row: 2'd0, col: 2'd0};
        case (c)
            "1":      begin k.row = 2'd0; k.col = 2'd0; end
            "2":      begin k.row = 2'd0; k.col = 2'd1; end
            "3":      begin k.row = 2'd0; k.col = 2'd2; end
            "4":      begin k.row = 2'd1; k.col = 2'd0; end
            "5":      begin k.row = 2'd1; k.col = 2'd1; end
            "6":      begin k.row = 2'd1; k.col = 2'd2; end
            "7":      begin k.row = 2'd2; k.col = 2'd0; end
            "8":      begin k.row = 2'd2; k.col = 2'd1; end
            "9":      begin k.row = 2'd2; k.col = 2'd2; end
            "*":      begin k.row = 2'd3; k.col = 2'd0; end
            "0":      begin k.row = 2'd3; k.col = 2'd1; end
            "#", ".": begin k.row = 2'd3; k.col = 2'd2; end
            "A", "a": begin k.row = 2'd0; k.col = 2'd3; end
            "B", "b": begin k.row = 2'd1; k.col = 2'd3; end
            "C", "c": begin k.row = 2'd2; k.col = 2'd3; end
            "D", "d": begin k.row = 2'd3; k.col = 2'd3; end
            default:  k.hit = 1'b0;
        endcase
        return k;
    endfunction

    // four restoring remainder steps, most significant bit first
    function automatic logic [7:0] rem_step4(
        input logic [7:0] rem,
        input logic [3:0] bits,
        input logic [7:0] d
    );
        logic [8:0] r9;
        logic [7:0] r;
        r = rem;
        for (int i = 3; i >= 0; i--) begin
            r9 = {r, bits[i]};
            if (r9 >= {1'b0, d}) begin
                r9 = r9 - {1'b0, d};
            end
            r = r9[7:0];
        end
        return r;
    endfunction

    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        return v[0] ? ((v >> 1) ^ NOISE_MASK) : (v >> 1);
    endfunction

endpackage

[rtl/dtmfs_seq.sv]
// digit sequencer: play state, phase accumulators, noise register and first pipeline stage
`timescale 1ns / 1ps

module dtmfs_seq
    import dtmfs_pkg::*;
#(
    parameter int SAMPLE_RATE = 8000,
    parameter int PHASE_BITS  = 16,
    parameter int SINE_DEPTH  = 256,
    localparam int IDX_W      = $clog2(SINE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_acc,
    input  logic             i_op,
    input  logic [7:0]       i_char,
    input  logic [15:0]      i_tone_samples,
    input  logic [15:0]      i_hiss_len,
    output t_ctl             o_ctl,
    output logic [IDX_W-1:0] o_lo_idx,
    output logic [IDX_W-1:0] o_hi_idx,
    output logic [15:0]      o_noise
);

    localparam int MUL_W = PHASE_BITS + 13;

    localparam logic [63:0] HALF_RATE = 64'(SAMPLE_RATE / 2);

    localparam logic [PHASE_BITS-1:0] ROW_STEP [4] = '{
        PHASE_BITS'(((64'(ROW_FREQ[0]) << PHASE_BITS) + HALF_RATE) / 64'(SAMPLE_RATE)),
        PHASE_BITS'(((64'(ROW_FREQ[1]) << PHASE_BITS) + HALF_RATE) / 64'(SAMPLE_RATE)),
        PHASE_BITS'(((64'(ROW_FREQ[2]) << PHASE_BITS) + HALF_RATE) / 64'(SAMPLE_RATE)),
        PHASE_BITS'(((64'(ROW_FREQ[3]) << PHASE_BITS) + HALF_RATE) / 64'(SAMPLE_RATE))
    };
    localparam logic [PHASE_BITS-1:0] COL_STEP [4] = '{
        PHASE_BITS'(((64'(COL_FREQ[0]) << PHASE_BITS) + HALF_RATE) / 64'(SAMPLE_RATE)),
        PHASE_BITS'(((64'(COL_FREQ[1]) << PHASE_BITS) + HALF_RATE) / 64'(SAMPLE_RATE)),
        PHASE_BITS'(((64'(COL_FREQ[2]) << PHASE_BITS) + HALF_RATE) / 64'(SAMPLE_RATE)),
        PHASE_BITS'(((64'(COL_FREQ[3]) << PHASE_BITS) + HALF_RATE) / 64'(SAMPLE_RATE))
    };

    logic [PHASE_BITS-1:0] r_lo_phase, n_lo_phase;
    logic [PHASE_BITS-1:0] r_hi_phase, n_hi_phase;
    logic [PHASE_BITS-1:0] r_lo_step, n_lo_step;
    logic [PHASE_BITS-1:0] r_hi_step, n_hi_step;
    logic [15:0]           r_count, n_count;
    t_mode                 r_mode, n_mode;
    logic [15:0]           r_noise, n_noise;

    t_ctl                  r_ctl, n_ctl;
    logic [IDX_W-1:0]      r_lo_idx, r_hi_idx;
    logic [15:0]           r_noise_out;

    t_key                  w_key;
    logic [15:0]           w_cnt_dec;
    logic [MUL_W-1:0]      w_lo_mul, w_hi_mul;

    assign w_key     = dial_key(i_char);
    assign w_cnt_dec = r_count - 16'd1;
    assign w_lo_mul  = MUL_W'(r_lo_phase) * MUL_W'(SINE_DEPTH);
    assign w_hi_mul  = MUL_W'(r_hi_phase) * MUL_W'(SINE_DEPTH);

    always_comb begin
        n_lo_phase = r_lo_phase;
        n_hi_phase = r_hi_phase;
        n_lo_step  = r_lo_step;
        n_hi_step  = r_hi_step;
        n_count    = r_count;
        n_mode     = r_mode;
        n_noise    = r_noise;
        n_ctl      = '{vld: i_acc & i_op, kind: r_mode, last: 1'b0};
        if (i_acc) begin
            if (!i_op) begin
                if (w_key.hit) begin
                    n_lo_step  = ROW_STEP[w_key.row];
                    n_hi_step  = COL_STEP[w_key.col];
                    n_lo_phase = '0;
                    n_hi_phase = '0;
                    if (i_tone_samples != 16'd0) begin
                        n_mode  = MODE_TONE;
                        n_count = i_tone_samples;
                    end else if (i_hiss_len != 16'd0) begin
                        n_mode  = MODE_HISS;
                        n_count = i_hiss_len;
                    end else begin
                        n_mode  = MODE_IDLE;
                        n_count = 16'd0;
                    end
                end
            end else begin
                case (r_mode)
                    MODE_TONE: begin
                        n_lo_phase = r_lo_phase + r_lo_step;
                        n_hi_phase = r_hi_phase + r_hi_step;
                        if (w_cnt_dec != 16'd0) begin
                            n_count = w_cnt_dec;
                        end else if (i_hiss_len != 16'd0) begin
                            n_mode  = MODE_HISS;
                            n_count = i_hiss_len;
                        end else begin
                            n_mode  = MODE_IDLE;
                            n_count = 16'd0;
                        end
                    end
                    MODE_HISS: begin
                        n_noise = lfsr_next(r_noise);
                        n_count = w_cnt_dec;
                        if (w_cnt_dec == 16'd0) begin
                            n_mode     = MODE_IDLE;
                            n_ctl.last = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo_phase <= '0;
            r_hi_phase <= '0;
            r_lo_step  <= '0;
            r_hi_step  <= '0;
            r_count    <= '0;
            r_mode     <= MODE_IDLE;
            r_noise    <= NOISE_SEED;
            r_ctl      <= '{vld: 1'b0, kind: MODE_IDLE, last: 1'b0};
        end else begin
            r_lo_phase <= n_lo_phase;
            r_hi_phase <= n_hi_phase;
            r_lo_step  <= n_lo_step;
            r_hi_step  <= n_hi_step;
            r_count    <= n_count;
            r_mode     <= n_mode;
            r_noise    <= n_noise;
            if (i_en) begin
                r_ctl <= n_ctl;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_idx    <= w_lo_mul[PHASE_BITS +: IDX_W];
            r_hi_idx    <= w_hi_mul[PHASE_BITS +: IDX_W];
            r_noise_out <= n_noise;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_lo_idx = r_lo_idx;
    assign o_hi_idx = r_hi_idx;
    assign o_noise  = r_noise_out;

endmodule

[rtl/dtmfs_tone.sv]
// two-tone path: sine lookup, level scaling, rounding and saturated sum
`timescale 1ns / 1ps

module dtmfs_tone
    import dtmfs_pkg::*;
#(
    parameter int SINE_DEPTH = 256,
    localparam int IDX_W     = $clog2(SINE_DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_lo_idx,
    input  logic [IDX_W-1:0] i_hi_idx,
    input  logic [6:0]       i_level,
    output logic [7:0]       o_tone
);

    logic signed [15:0] w_sine [SINE_DEPTH];

    for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_sine
        localparam logic [63:0] K4   = 64'(k) * 64'd4;
        localparam logic [63:0] QUAD = K4 / 64'(SINE_DEPTH);
        localparam logic [63:0] T    = ((K4 % 64'(SINE_DEPTH)) << 16) / 64'(SINE_DEPTH);
        localparam logic [15:0] MAG  = ((QUAD & 64'd1) != 64'd0) ?
                                       quarter_sine(64'd65536 - T) : quarter_sine(T);
        localparam logic signed [15:0] VAL = ((QUAD & 64'd2) != 64'd0) ?
                                             -$signed(MAG) : $signed(MAG);
        assign w_sine[k] = VAL;
    end

    logic signed [15:0] r_lo_sin, r_hi_sin;
    logic signed [22:0] r_lo_prod, r_hi_prod;
    logic [7:0]         r_tone;

    logic [21:0]        w_lo_abs, w_hi_abs;
    logic [7:0]         w_lo_mag, w_hi_mag;
    logic signed [9:0]  w_lo_val, w_hi_val, w_sum;
    logic [7:0]         w_sat;

    // round half away from zero, magnitude then sign
    assign w_lo_abs = r_lo_prod[22] ? 22'(-r_lo_prod) : r_lo_prod[21:0];
    assign w_hi_abs = r_hi_prod[22] ? 22'(-r_hi_prod) : r_hi_prod[21:0];
    assign w_lo_mag = 8'((23'(w_lo_abs) + 23'd16384) >> 15);
    assign w_hi_mag = 8'((23'(w_hi_abs) + 23'd16384) >> 15);
    assign w_lo_val = r_lo_prod[22] ? -$signed({2'b00, w_lo_mag}) : $signed({2'b00, w_lo_mag});
    assign w_hi_val = r_hi_prod[22] ? -$signed({2'b00, w_hi_mag}) : $signed({2'b00, w_hi_mag});
    assign w_sum    = $signed({2'b00, MID_SAMPLE}) + w_lo_val + w_hi_val;

    always_comb begin
        if (w_sum < 10'sd0) begin
            w_sat = 8'd0;
        end else if (w_sum > 10'sd255) begin
            w_sat = 8'd255;
        end else begin
            w_sat = w_sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo_sin  <= w_sine[i_lo_idx];
            r_hi_sin  <= w_sine[i_hi_idx];
            r_lo_prod <= 23'(r_lo_sin) * $signed({1'b0, i_level});
            r_hi_prod <= 23'(r_hi_sin) * $signed({1'b0, i_level});
            r_tone    <= w_sat;
        end
    end

    assign o_tone = r_tone;

endmodule

[rtl/dtmfs_hmod.sv]
// hiss scaling: noise value modulo hiss level, four bits per stage
`timescale 1ns / 1ps

module dtmfs_hmod
    import dtmfs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_noise,
    input  logic [7:0]  i_level,
    output logic [7:0]  o_rem
);

    logic [7:0]  r_rem2, r_rem3, r_rem4;
    logic [11:0] r_bits2;
    logic [7:0]  r_bits3;
    logic [3:0]  r_bits4;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem2  <= rem_step4(8'd0, i_noise[15:12], i_level);
            r_bits2 <= i_noise[11:0];
            r_rem3  <= rem_step4(r_rem2, r_bits2[11:8], i_level);
            r_bits3 <= r_bits2[7:0];
            r_rem4  <= rem_step4(r_rem3, r_bits3[7:4], i_level);
            r_bits4 <= r_bits3[3:0];
        end
    end

    // last four steps feed the output register
    assign o_rem = rem_step4(r_rem4, r_bits4, i_level);

endmodule

[rtl/dtmf_dial_sequencer_core.sv]
// top level of the dial sequencer: ports, configuration registers and result stage
//
// channel  dir  accept               payload
// s        in   tvalid & tready      tuser = op, tdata = dial_char
// m        out  tvalid & tready      tdata = sample, tuser = {in_hiss, active}, tlast = last
// cfg      in   we                   idx 0 tone_samples, 1 tone_level, 2 hiss_level
//
// one item per cycle unless the result stage stalls; a sample tick's result passes
// the sine lookup, multiply and remainder stages and the result register. a start item
// gives no result. synchronous reset, no clearing pass. while a result waits the whole
// pipe holds and o_s_tready is low.
`timescale 1ns / 1ps

module dtmf_dial_sequencer_core
    import dtmfs_pkg::*;
#(
    parameter int SAMPLE_RATE = 8000,
    parameter int PHASE_BITS  = 16,
    parameter int SINE_DEPTH  = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic                  i_s_tuser,   // [0] op
    input  logic [7:0]            i_s_tdata,   // [7:0] dial_char
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [7:0]            o_m_tdata,   // [7:0] sample
    output logic [1:0]            o_m_tuser,   // [0] active, [1] in_hiss
    output logic                  o_m_tlast,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(SINE_DEPTH);

    logic [15:0] r_tone_samples;
    logic [15:0] r_hiss_len;
    logic [6:0]  r_tone_level;
    logic [7:0]  r_hiss_div;

    logic [32:0] w_third_prod;
    logic        w_en;
    logic        w_acc;

    t_ctl             w_ctl1;
    logic [IDX_W-1:0] w_lo_idx, w_hi_idx;
    logic [15:0]      w_noise;
    logic [7:0]       w_tone;
    logic [7:0]       w_rem;

    t_ctl       r_ctl [2:4];
    logic       r_out_vld;
    logic [7:0] r_out_sample;
    logic       r_out_active;
    logic       r_out_hiss;
    logic       r_out_last;
    logic [7:0] n_out_sample;

    assign w_en         = !r_out_vld || i_m_tready;
    assign o_s_tready   = w_en;
    assign w_acc        = i_s_tvalid && w_en;
    assign w_third_prod = 33'(i_cfg_data) * THIRD_RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tone_samples <= RST_TONE_SAMPLES;
            r_hiss_len     <= RST_HISS_LEN;
            r_tone_level   <= RST_TONE_LEVEL;
            r_hiss_div     <= RST_HISS_LEVEL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TONE_SAMPLES: begin
                    r_tone_samples <= i_cfg_data;
                    r_hiss_len     <= w_third_prod[THIRD_SHIFT +: 16];
                end
                CFG_TONE_LEVEL: r_tone_level <= i_cfg_data[6:0];
                CFG_HISS_LEVEL: begin
                    // level zero acts as one
                    r_hiss_div <= (i_cfg_data[7:0] == 8'd0) ? 8'd1 : i_cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    dtmfs_seq #(
        .SAMPLE_RATE (SAMPLE_RATE),
        .PHASE_BITS  (PHASE_BITS),
        .SINE_DEPTH  (SINE_DEPTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_acc          (w_acc),
        .i_op           (i_s_tuser),
        .i_char         (i_s_tdata),
        .i_tone_samples (r_tone_samples),
        .i_hiss_len     (r_hiss_len),
        .o_ctl          (w_ctl1),
        .o_lo_idx       (w_lo_idx),
        .o_hi_idx       (w_hi_idx),
        .o_noise        (w_noise)
    );

    dtmfs_tone #(
        .SINE_DEPTH (SINE_DEPTH)
    ) u_tone (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_lo_idx (w_lo_idx),
        .i_hi_idx (w_hi_idx),
        .i_level  (r_tone_level),
        .o_tone   (w_tone)
    );

    dtmfs_hmod u_hmod (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_noise (w_noise),
        .i_level (r_hiss_div),
        .o_rem   (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 2; s <= 4; s++) begin
                r_ctl[s] <= '{vld: 1'b0, kind: MODE_IDLE, last: 1'b0};
            end
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_ctl[2]  <= w_ctl1;
            r_ctl[3]  <= r_ctl[2];
            r_ctl[4]  <= r_ctl[3];
            r_out_vld <= r_ctl[4].vld;
        end
    end

    always_comb begin
        case (r_ctl[4].kind)
            MODE_TONE: n_out_sample = w_tone;
            MODE_HISS: n_out_sample = w_rem;
            default:   n_out_sample = MID_SAMPLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_sample <= n_out_sample;
            r_out_active <= (r_ctl[4].kind == MODE_TONE) || (r_ctl[4].kind == MODE_HISS);
            r_out_hiss   <= (r_ctl[4].kind == MODE_HISS);
            r_out_last   <= r_ctl[4].last;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_sample;
    assign o_m_tuser  = {r_out_hiss, r_out_active};
    assign o_m_tlast  = r_out_last;

endmodule

[rtl/dtmfs_chk.sv]
// port-level checks on the dial sequencer, bound to the top level
`timescale 1ns / 1ps

module dtmfs_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [1:0] o_m_tuser,
    input logic       o_m_tlast
);

    // final hiss item is flagged as hiss and active
    a_last_is_hiss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> o_m_tuser[1] && o_m_tuser[0])
        else $error("last raised outside hiss");

    a_hiss_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[1] |-> o_m_tuser[0])
        else $error("hiss item not marked active");

    a_idle_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser[0] |-> o_m_tdata == 8'd128)
        else $error("idle item is not midpoint");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result stage");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

endmodule

bind dtmf_dial_sequencer_core dtmfs_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

[test/dtmf_dial_sequencer_core_tb.sv]
// testbench for the dial sequencer core: random digits and ticks, a directed dial plan, then more random ones
`timescale 1ns / 1ps

module dtmf_dial_sequencer_core_tb
    import dtmfs_pkg::*;
();

    localparam int RATE  = 8000;
    localparam int PBITS = 16;
    localparam int DEPTH = 256;

    localparam logic OP_DIAL = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic [7:0] sample;
        logic       active;
        logic       in_hiss;
        logic       last;
    } t_tone_out;

    typedef struct packed {
        logic      op;
        logic [7:0] ch;
        logic      typed;
        t_tone_out res;
    } t_row;

    localparam t_tone_out NO_OUT     = '0;
    localparam t_tone_out AT_REST    = {8'd128, 1'b0, 1'b0, 1'b0};
    localparam t_tone_out FIRST_TONE = {8'd128, 1'b1, 1'b0, 1'b0};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic                  i_s_tuser;   // [0] op
    logic [7:0]            i_s_tdata;   // [7:0] dial_char
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [7:0]            o_m_tdata;   // [7:0] sample
    logic [1:0]            o_m_tuser;   // [0] active, [1] in_hiss
    logic                  o_m_tlast;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    logic      row_typed;
    t_tone_out row_res;
    bit        src_calm;
    bit        snk_calm;
    int        n_bad;
    int        sent;

    // predictor state and register copies
    int          sin_q15 [DEPTH];
    logic [15:0] ph_lo, ph_hi, inc_lo, inc_hi;
    logic [15:0] remaining;
    t_mode       mode;
    logic [15:0] lfsr;
    logic [15:0] cfg_len;
    logic [6:0]  cfg_level;
    logic [7:0]  cfg_hiss;

    t_tone_out pending_samples [$];

    string keys = "0123456789*#ABCDabcd.";

    t_row plan [25] = '{
        {OP_TICK, 8'h00, 1'b0, NO_OUT},
        {OP_DIAL, 8'h00, 1'b0, NO_OUT},
        {OP_DIAL, 8'hFF, 1'b0, NO_OUT},
        {OP_DIAL, "/",   1'b0, NO_OUT},
        {OP_TICK, 8'hFF, 1'b0, NO_OUT},
        {OP_DIAL, "1",   1'b0, NO_OUT},
        {OP_TICK, 8'h55, 1'b1, FIRST_TONE},
        {OP_TICK, 8'hAA, 1'b0, NO_OUT},
        {OP_DIAL, "*",   1'b0, NO_OUT},
        {OP_TICK, 8'h00, 1'b1, FIRST_TONE},
        {OP_TICK, 8'h0F, 1'b0, NO_OUT},
        {OP_TICK, 8'hF0, 1'b0, NO_OUT},
        {OP_TICK, 8'h33, 1'b0, NO_OUT},
        {OP_TICK, 8'hCC, 1'b0, NO_OUT},
        {OP_TICK, 8'h80, 1'b1, AT_REST},
        {OP_DIAL, "0",   1'b0, NO_OUT},
        {OP_DIAL, "#",   1'b0, NO_OUT},
        {OP_DIAL, ".",   1'b0, NO_OUT},
        {OP_DIAL, "D",   1'b0, NO_OUT},
        {OP_DIAL, "d",   1'b0, NO_OUT},
        {OP_TICK, 8'h01, 1'b1, FIRST_TONE},
        {OP_DIAL, "9",   1'b0, NO_OUT},
        {OP_DIAL, "A",   1'b0, NO_OUT},
        {OP_TICK, 8'hFE, 1'b1, FIRST_TONE},
        {OP_TICK, 8'h7F, 1'b0, NO_OUT}
    };

    dtmf_dial_sequencer_core #(
        .SAMPLE_RATE(RATE),
        .PHASE_BITS (PBITS),
        .SINE_DEPTH (DEPTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // quarter-wave sine, t in q16, q15 result
    function automatic logic [15:0] poly_quarter(input logic [63:0] t);
        logic [63:0] sq, inner, outer, f, q;
        sq    = (t * t) >> 16;
        inner = 64'd42111 - ((64'd4737 * sq) >> 16);
        outer = 64'd102919 - ((sq * inner) >> 16);
        f     = (t * outer) >> 16;
        q     = (f + 64'd1) >> 1;
        if (q > 64'd32767) begin
            q = 64'd32767;
        end
        return q[15:0];
    endfunction

    function automatic logic [15:0] step_for(input logic [1:0] sel, input bit is_col);
        longint unsigned hz, s;
        if (is_col) begin
            case (sel)
                2'd0:    hz = 1209;
                2'd1:    hz = 1336;
                2'd2:    hz = 1477;
                default: hz = 1633;
            endcase
        end else begin
            case (sel)
                2'd0:    hz = 697;
                2'd1:    hz = 770;
                2'd2:    hz = 852;
                default: hz = 941;
            endcase
        end
        s = ((hz << PBITS) + RATE / 2) / RATE;
        return s[15:0];
    endfunction

    // {hit, row, col}
    function automatic logic [4:0] key_of(input logic [7:0] ch);
        logic [7:0] u, d, q3, r3;
        u = ch;
        if (u >= "a" && u <= "d") begin
            u = u - 8'd32;
        end
        if (u == ".") begin
            u = "#";
        end
        d  = u - "1";
        q3 = d / 8'd3;
        r3 = d % 8'd3;
        if (u >= "1" && u <= "9") begin
            return {1'b1, q3[1:0], r3[1:0]};
        end
        d = u - "A";
        if (u >= "A" && u <= "D") begin
            return {1'b1, d[1:0], 2'd3};
        end
        case (u)
            "0":     return {1'b1, 2'd3, 2'd1};
            "*":     return {1'b1, 2'd3, 2'd0};
            "#":     return {1'b1, 2'd3, 2'd2};
            default: return 5'd0;
        endcase
    endfunction

    function automatic int tone_part(input logic [15:0] ph);
        longint unsigned idx;
        int s, p, mag, lvl;
        idx = ({48'd0, ph} * DEPTH) >> PBITS;
        if (idx >= DEPTH) begin
            idx = DEPTH - 1;
        end
        s   = sin_q15[idx];
        lvl = int'(cfg_level);
        p   = s * lvl;
        mag = ((p < 0 ? -p : p) + 16384) / 32768;
        return p < 0 ? -mag : mag;
    endfunction

    task automatic settle_mode();
        if (mode == MODE_TONE && remaining == 16'd0) begin
            mode      = MODE_HISS;
            remaining = cfg_len / 16'd3;
        end
        if (mode == MODE_HISS && remaining == 16'd0) begin
            mode = MODE_IDLE;
        end
    endtask

    task automatic dial_step(input logic op, input logic [7:0] ch,
                             output bit made, output t_tone_out res);
        logic [4:0]  k;
        logic [15:0] div, rem16;
        int          v;
        made = 1'b0;
        res  = AT_REST;
        if (op == OP_DIAL) begin
            k = key_of(ch);
            if (k[4]) begin
                inc_lo    = step_for(k[3:2], 1'b0);
                inc_hi    = step_for(k[1:0], 1'b1);
                ph_lo     = 16'd0;
                ph_hi     = 16'd0;
                mode      = MODE_TONE;
                remaining = cfg_len;
                settle_mode();
            end
        end else begin
            made = 1'b1;
            case (mode)
                MODE_TONE: begin
                    v = 128 + tone_part(ph_lo) + tone_part(ph_hi);
                    if (v < 0) begin
                        v = 0;
                    end
                    if (v > 255) begin
                        v = 255;
                    end
                    res.sample = v[7:0];
                    res.active = 1'b1;
                    ph_lo      = ph_lo + inc_lo;
                    ph_hi      = ph_hi + inc_hi;
                    remaining  = remaining - 16'd1;
                    settle_mode();
                end
                MODE_HISS: begin
                    div  = (cfg_hiss == 8'd0) ? 16'd1 : {8'd0, cfg_hiss};
                    lfsr = lfsr[0] ? ((lfsr >> 1) ^ 16'hB400) : (lfsr >> 1);
                    rem16 = lfsr % div;
                    res.sample  = rem16[7:0];
                    res.active  = 1'b1;
                    res.in_hiss = 1'b1;
                    remaining   = remaining - 16'd1;
                    res.last    = (remaining == 16'd0);
                    settle_mode();
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge i_clk) begin : watch
        bit        made;
        t_tone_out want, got;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_TONE_SAMPLES: cfg_len   = i_cfg_data;
                    CFG_TONE_LEVEL:   cfg_level = i_cfg_data[6:0];
                    CFG_HISS_LEVEL:   cfg_hiss  = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && o_s_tready) begin
                dial_step(i_s_tuser, i_s_tdata, made, want);
                if (made) begin
                    pending_samples.push_back(row_typed ? row_res : want);
                end
            end
            if (o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata, o_m_tuser[0], o_m_tuser[1], o_m_tlast};
                if (pending_samples.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10) begin
                        $display("%0t: unexpected item sample %0d active %0b hiss %0b last %0b",
                                 $time, got.sample, got.active, got.in_hiss, got.last);
                    end
                end else begin
                    want = pending_samples.pop_front();
                    if (got.sample !== want.sample || got.active !== want.active ||
                        got.in_hiss !== want.in_hiss || got.last !== want.last) begin
                        n_bad++;
                        if (n_bad <= 10) begin
                            $display("%0t: mismatch sample %0d/%0d active %0b/%0b",
                                     $time, want.sample, got.sample, want.active, got.active,
                                     " hiss %0b/%0b last %0b/%0b (exp/got)",
                                     want.in_hiss, got.in_hiss, want.last, got.last);
                        end
                    end
                end
            end
        end
    end

    task automatic send(input logic op, input logic [7:0] ch,
                        input logic typed, input t_tone_out res);
        int gap;
        gap = src_calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= ch;
        row_typed  <= typed;
        row_res    <= res;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    // drain, write registers picked by mask (bit 0 length, 1 tone level, 2 hiss level),
    // then play n random items
    task automatic run_setting(input logic [15:0] ts, input logic [6:0] tl,
                               input logic [7:0] hl, input logic [2:0] mask, input int n);
        int         done, span, r;
        logic [7:0] ch;
        logic [4:0] k;
        i_s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        if (mask[0]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_TONE_SAMPLES;
            i_cfg_data <= ts;
            @(negedge i_clk);
        end
        if (mask[1]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_TONE_LEVEL;
            i_cfg_data <= {9'd0, tl};
            @(negedge i_clk);
        end
        if (mask[2]) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_HISS_LEVEL;
            i_cfg_data <= {8'd0, hl};
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        src_calm = ($urandom_range(0, 3) == 0);
        snk_calm = ($urandom_range(0, 3) == 0);
        done = 0;
        while (done < n) begin
            span = cfg_len + cfg_len / 3 + 2;
            if (span > 200) begin
                span = 200;
            end
            r  = $urandom_range(0, span);
            ch = 8'($urandom_range(0, 255));
            if (r == 0) begin
                send(OP_DIAL, keys[$urandom_range(0, keys.len() - 1)], 1'b0, NO_OUT);
                done++;
            end else if (r == 1) begin
                send(OP_DIAL, ch, 1'b0, NO_OUT);
                k = key_of(ch);
                if (k[4]) begin
                    done++;
                end
            end else begin
                send(OP_TICK, ch, 1'b0, NO_OUT);
                done++;
            end
        end
        sent += done;
    endtask

    initial begin : receiver
        int gap;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            gap = snk_calm ? 0 : $urandom_range(0, 13);
            if (gap != 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin : main
        logic [63:0] kk, quad, t;
        logic [15:0] mag;
        logic [15:0] ts;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser  = OP_TICK;
        i_s_tdata  = 8'd0;
        i_m_tready = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_TONE_SAMPLES;
        i_cfg_data = 16'd0;
        row_typed  = 1'b0;
        row_res    = NO_OUT;
        src_calm   = 1'b0;
        snk_calm   = 1'b0;
        n_bad      = 0;
        sent       = 0;

        for (int i = 0; i < DEPTH; i++) begin
            kk   = 64'(i) * 64'd4;
            quad = kk / DEPTH;
            t    = ((kk % DEPTH) << 16) / DEPTH;
            mag  = quad[0] ? poly_quarter(64'd65536 - t) : poly_quarter(t);
            sin_q15[i] = quad[1] ? -int'(mag) : int'(mag);
        end
        ph_lo     = 16'd0;
        ph_hi     = 16'd0;
        inc_lo    = 16'd0;
        inc_hi    = 16'd0;
        remaining = 16'd0;
        mode      = MODE_IDLE;
        lfsr      = 16'hACE1;
        cfg_len   = 16'd1000;
        cfg_level = 7'd70;
        cfg_hiss  = 8'd3;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // register values from reset
        run_setting(16'd0, 7'd0, 8'd0, 3'b000, 60);

        run_setting(16'd4, 7'd127, 8'd255, 3'b111, 0);
        foreach (plan[i]) begin
            send(plan[i].op, plan[i].ch, plan[i].typed, plan[i].res);
        end
        row_typed <= 1'b0;

        run_setting(16'd3, 7'd0, 8'd1, 3'b111, 80);
        run_setting(16'd0, 7'd127, 8'd0, 3'b111, 60);
        run_setting(16'd1, 7'd64, 8'd2, 3'b111, 60);
        run_setting(16'd2, 7'd127, 8'd255, 3'b111, 60);
        run_setting(16'hFFFF, 7'd127, 8'd128, 3'b111, 150);
        run_setting(16'd12, 7'd0, 8'd0, 3'b001, 80);

        while (sent < 1000) begin
            case ($urandom_range(0, 7))
                0:       ts = 16'($urandom_range(0, 2));
                1:       ts = 16'($urandom_range(41, 400));
                default: ts = 16'($urandom_range(3, 40));
            endcase
            run_setting(ts, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                        3'($urandom_range(1, 7)), 100);
        end

        i_s_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_bad == 0 && pending_samples.size() == 0) begin
            $display("** dtmf_dial_sequencer_core: PASSED **");
        end else begin
            $display("** dtmf_dial_sequencer_core: FAILED **");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("** dtmf_dial_sequencer_core: FAILED **");
        $finish;
    end

endmodule
